[rtl/core/ipv4_dotted_quad_parser_assert.svh]
// Assertion macros for the dotted-quad parser.
`ifndef IPV4_DOTTED_QUAD_PARSER_ASSERT_SVH
`define IPV4_DOTTED_QUAD_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on the rising clock edge, skipped while reset is high.
`define IDQP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("idqp assertion failed");

// Checked on the rising clock edge, also during reset.
`define IDQP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("idqp assertion failed");

`else

`define IDQP_ASSERT(label, clk, rst, prop)
`define IDQP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/core/idqp_pkg.sv]
package idqp_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [31:0] address;
      logic        valid_res;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_DIGITS,
      PH_IGNORE
   } phase_type;

   localparam int ACC_W      = 9;
   localparam int PROD_W     = 12;
   localparam int DOT_W      = 3;
   localparam int ADDR_LO_W  = 24;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [ACC_W-1:0]  OCTET_MAX   = 9'd255;
   localparam logic [ACC_W-1:0]  ACC_SAT     = 9'd256;
   localparam logic [PROD_W-1:0] PROD_MAX    = 12'd255;
   localparam logic [DOT_W-1:0]  DOTS_NEEDED = 3'd3;
   localparam logic [DOT_W-1:0]  DOTS_SAT    = 3'd7;

   function automatic logic is_blank(input logic [7:0] c);
      logic hit;
      hit = (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
      return hit;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      logic hit;
      hit = c inside {[CHAR_ZERO:CHAR_NINE]};
      return hit;
   endfunction

endpackage

[rtl/core/ipv4_dotted_quad_parser.sv]
// Dotted-quad IPv4 string parser.
//
// Request channel (req_valid/req_ready/req_data): one character per request,
// then one request with is_end set. Each octet is read like atoi: leading
// whitespace skipped, optional sign, digits up to the first non-digit, rest
// ignored up to the next dot. Character requests produce no response.
// Response channel (rsp_valid/rsp_ready/rsp_data): one response per end
// request, with the address (first octet in bits 7..0) and valid_res. An
// invalid string (octet above 255, negative octet, dot count other than
// three, more than MAX_CHARS characters) returns address 0, valid_res 0.
// Throughput: one request per cycle unless req_ready is low; each request
// updates the running octet state as it is taken. Latency: the response is
// registered and appears the cycle after the end request is accepted.
// Reset clears all parse state and rsp_valid (rsp_data is not reset); the block is
// ready right after reset. When the receiver stalls, the response holds and
// req_ready drops only if another end request arrives with the register full;
// character requests are still taken while a response waits.
module ipv4_dotted_quad_parser #(
   parameter int MAX_CHARS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  idqp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output idqp_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_CHARS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

   logic [idqp_pkg::ACC_W-1:0]     acc_ff, acc_in;
   idqp_pkg::phase_type            phase_ff, phase_in;
   logic                           neg_ff, neg_in;
   logic [idqp_pkg::DOT_W-1:0]     dots_ff, dots_in;
   logic [idqp_pkg::ADDR_LO_W-1:0] partial_ff, partial_in;
   logic                           err_ff, err_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   idqp_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                           accept;
   logic                           out_free;
   logic                           octet_bad;
   logic [idqp_pkg::PROD_W-1:0]    prod;
   logic                           ok;
   logic                           end_taken;
   logic                           parse_idle;
   logic                           rsp_invalid;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = out_free || !req_data.is_end;
   assign accept    = req_valid && req_ready;

   assign octet_bad = (acc_ff > idqp_pkg::OCTET_MAX) || (neg_ff && (acc_ff != '0));
   assign prod = idqp_pkg::PROD_W'(acc_ff) * idqp_pkg::PROD_W'(10)
               + idqp_pkg::PROD_W'(req_data.ch[3:0]);
   assign ok = !octet_bad && !err_ff && (dots_ff == idqp_pkg::DOTS_NEEDED);

   always_comb begin
      acc_in       = acc_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      dots_in      = dots_ff;
      partial_in   = partial_ff;
      err_in       = err_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         if (req_data.is_end) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.valid_res = ok;
            rsp_data_in.address   = ok ? {acc_ff[7:0], partial_ff} : '0;
            // clear everything for the next string
            acc_in     = '0;
            phase_in   = idqp_pkg::PH_SKIP;
            neg_in     = 1'b0;
            dots_in    = '0;
            partial_in = '0;
            err_in     = 1'b0;
            count_in   = '0;
         end else begin
            if (count_ff >= CNT_MAX) begin
               err_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end

            if (req_data.ch == idqp_pkg::CHAR_DOT) begin
               if (octet_bad) begin
                  err_in = 1'b1;
               end
               acc_in   = '0;
               phase_in = idqp_pkg::PH_SKIP;
               neg_in   = 1'b0;
               case (dots_ff)
                  3'd0: begin
                     partial_in[7:0] = partial_ff[7:0] | acc_ff[7:0];
                  end
                  3'd1: begin
                     partial_in[15:8] = partial_ff[15:8] | acc_ff[7:0];
                  end
                  3'd2: begin
                     partial_in[23:16] = partial_ff[23:16] | acc_ff[7:0];
                  end
                  default: begin
                     // octets past the third dot are checked, not stored
                  end
               endcase
               if (dots_ff != idqp_pkg::DOTS_SAT) begin
                  dots_in = dots_ff + idqp_pkg::DOT_W'(1);
               end
            end else if (idqp_pkg::is_digit(req_data.ch)) begin
               if (phase_ff != idqp_pkg::PH_IGNORE) begin
                  acc_in   = (prod > idqp_pkg::PROD_MAX) ? idqp_pkg::ACC_SAT
                                                         : prod[idqp_pkg::ACC_W-1:0];
                  phase_in = idqp_pkg::PH_DIGITS;
               end
            end else begin
               case (phase_ff)
                  idqp_pkg::PH_SKIP: begin
                     if (idqp_pkg::is_blank(req_data.ch)) begin
                        phase_in = idqp_pkg::PH_SKIP;
                     end else if (req_data.ch == idqp_pkg::CHAR_PLUS ||
                                  req_data.ch == idqp_pkg::CHAR_MINUS) begin
                        neg_in   = (req_data.ch == idqp_pkg::CHAR_MINUS);
                        phase_in = idqp_pkg::PH_DIGITS;
                     end else begin
                        phase_in = idqp_pkg::PH_IGNORE;
                     end
                  end
                  default: begin
                     phase_in = idqp_pkg::PH_IGNORE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         phase_ff     <= idqp_pkg::PH_SKIP;
         neg_ff       <= 1'b0;
         dots_ff      <= '0;
         partial_ff   <= '0;
         err_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         dots_ff      <= dots_in;
         partial_ff   <= partial_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign end_taken   = accept && req_data.is_end;
   assign parse_idle  = (dots_ff == '0) && (count_ff == '0) && !err_ff;
   assign rsp_invalid = rsp_valid && !rsp_data.valid_res;

`include "ipv4_dotted_quad_parser_assert.svh"

   `IDQP_ASSERT(a_end_gives_rsp, clock, reset, end_taken |=> rsp_valid)
   `IDQP_ASSERT(a_end_clears, clock, reset, end_taken |=> parse_idle)
   `IDQP_ASSERT(a_invalid_zero, clock, reset, rsp_invalid |-> (rsp_data.address == '0))
   `IDQP_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_MAX)

endmodule
